[hdl/wsvf_pkg.sv]
// Shared types, field widths, register codes and reset values of the wheel
// stroke and velocity filter. Used by the channel interfaces and the top level.
// Has no dependencies.
package wsvf_pkg;

	// Field widths.
	localparam int WHEEL_W  = 3;
	localparam int MV_W     = 13;
	localparam int STROKE_W = 10;
	localparam int RETAIN_W = 16;
	localparam int GAIN_W   = 20;
	localparam int POS_W    = 10;
	localparam int VEL_W    = 16;

	// Datapath widths of the scaling and filter arithmetic.
	localparam int PROD_W  = MV_W + STROKE_W;
	localparam int DELTA_W = POS_W + 1;
	localparam int ACC_W   = 34;
	localparam int FRAC_W  = 16;

	// Bit-serial step counts of the scaling multiply, the divide and the filter.
	localparam int MUL_STEPS = STROKE_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int VEL_STEPS = GAIN_W;

	// Default number of wheels.
	localparam int WHEELS_DEFAULT = 6;

	typedef logic [WHEEL_W-1:0]       wheel_t;
	typedef logic [MV_W-1:0]          mv_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic signed [VEL_W-1:0]  vel_t;

	localparam pos_t POS_MAX = '1;
	localparam vel_t VEL_MAX = 16'sh7FFF;
	localparam vel_t VEL_MIN = 16'sh8000;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_MV      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MV      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_STROKE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETAIN_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN   = 3'd4;

	// Register reset values.
	localparam mv_t                   MIN_MV_RESET      = 13'd500;
	localparam mv_t                   MAX_MV_RESET      = 13'd4500;
	localparam logic [STROKE_W-1:0]   FULL_STROKE_RESET = 10'd485;
	localparam logic [RETAIN_W-1:0]   RETAIN_RESET      = 16'd59578;
	localparam logic [GAIN_W-1:0]     GAIN_RESET        = 20'd297890;

endpackage

[hdl/wsvf_sample_if.sv]
// Input channel of the wheel stroke and velocity filter: one sensor sample.
// Depends on wsvf_pkg.
interface wsvf_sample_if;
	logic              valid;
	logic              ready;
	wsvf_pkg::wheel_t  wheel;
	wsvf_pkg::mv_t     sample_mv;

	modport source (output valid, output wheel, output sample_mv, input ready);
	modport sink   (input valid, input wheel, input sample_mv, output ready);
endinterface

[hdl/wsvf_result_if.sv]
// Output channel of the wheel stroke and velocity filter: one result per sample.
// Depends on wsvf_pkg.
interface wsvf_result_if;
	logic              valid;
	logic              ready;
	wsvf_pkg::wheel_t  wheel_out;
	wsvf_pkg::pos_t    position_mm;
	wsvf_pkg::vel_t    velocity;
	wsvf_pkg::pos_t    avg_height;
	wsvf_pkg::vel_t    avg_velocity;
	logic              range_error;

	modport source (output valid, output wheel_out, output position_mm, output velocity,
		output avg_height, output avg_velocity, output range_error, input ready);
	modport sink   (input valid, input wheel_out, input position_mm, input velocity,
		input avg_height, input avg_velocity, input range_error, output ready);
endinterface

[hdl/wsvf_cfg_if.sv]
// Configuration write channel of the wheel stroke and velocity filter.
// Depends on wsvf_pkg.
interface wsvf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wsvf_pkg::CFG_IDX_W-1:0]      index;
	logic [wsvf_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/wheel_stroke_velocity_filter_unit.sv]
// Top level of the wheel stroke and velocity filter: sequencer and bit-serial datapath.
// Depends on wsvf_pkg and the interfaces wsvf_sample_if, wsvf_result_if, wsvf_cfg_if.

// One sample is taken at a time: the next one is accepted only back in the
// idle state, after the last result has been computed. The work is done by
// the bit-serial arithmetic: 10 shift-add steps scale the millivolt offset
// by the full stroke, 23 restoring steps divide by the sensor span, 20
// shift-add steps form the filtered velocity, and one restoring step per bit
// of the velocity sum, which is 16 plus ceil(log2(WHEELS)) bits wide,
// produces both wheel averages. A finished result sits in an output register,
// so the next sample is taken while it waits. Configuration writes are taken
// at any time and belong in the gaps between samples.
module wheel_stroke_velocity_filter_unit #(
	parameter int WHEELS = wsvf_pkg::WHEELS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wsvf_cfg_if.sink              cfg,
	wsvf_sample_if.sink           samples,
	wsvf_result_if.source         results
);

	localparam int IDX_W     = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int PSUM_W    = wsvf_pkg::POS_W + $clog2(WHEELS);
	localparam int VSUM_W    = wsvf_pkg::VEL_W + $clog2(WHEELS);
	localparam int AVG_STEPS = VSUM_W;
	localparam int RW        = $clog2(WHEELS) + 2;
	localparam int MAX_STEPS = (wsvf_pkg::DIV_STEPS > AVG_STEPS) ?
		wsvf_pkg::DIV_STEPS : AVG_STEPS;
	localparam int CNT_W     = $clog2(MAX_STEPS);
	localparam int QW        = wsvf_pkg::ACC_W - wsvf_pkg::FRAC_W;
	localparam int MV_W      = wsvf_pkg::MV_W;
	localparam int PROD_W    = wsvf_pkg::PROD_W;
	localparam int POS_W     = wsvf_pkg::POS_W;
	localparam int VEL_W     = wsvf_pkg::VEL_W;
	localparam int ACC_W     = wsvf_pkg::ACC_W;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_VEL  = 4'd4;
	localparam logic [3:0] ST_SUM  = 4'd5;
	localparam logic [3:0] ST_AVGL = 4'd6;
	localparam logic [3:0] ST_AVG  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              res_valid_q;

	// Configuration registers.
	wsvf_pkg::mv_t                   min_q;
	wsvf_pkg::mv_t                   max_q;
	logic [wsvf_pkg::STROKE_W-1:0]   fs_q;
	logic [wsvf_pkg::RETAIN_W-1:0]   retain_q;
	logic [wsvf_pkg::GAIN_W-1:0]     gain_q;

	// Per-wheel state and running sums.
	wsvf_pkg::pos_t                  wpos_q [WHEELS];
	wsvf_pkg::vel_t                  wvel_q [WHEELS];
	logic [PSUM_W-1:0]               psum_q;
	logic signed [VSUM_W-1:0]        vsum_q;

	// Datapath registers.
	wsvf_pkg::wheel_t                wheel_q;
	logic                            err_q;
	logic                            zero_q;
	wsvf_pkg::mv_t                   span_q;
	logic [PROD_W-1:0]               prod_q;
	logic [PROD_W-1:0]               mcand_q;
	logic [wsvf_pkg::STROKE_W-1:0]   mplier_q;
	wsvf_pkg::mv_t                   rem_q;
	wsvf_pkg::pos_t                  pos_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [ACC_W-1:0]         ma_q;
	logic signed [ACC_W-1:0]         mb_q;
	logic [wsvf_pkg::RETAIN_W-1:0]   ra_q;
	logic [wsvf_pkg::GAIN_W-1:0]     rb_q;
	wsvf_pkg::pos_t                  res_pos_q;
	wsvf_pkg::vel_t                  res_vel_q;
	logic [VSUM_W-1:0]               pdiv_q;
	logic [VSUM_W-1:0]               vdiv_q;
	logic                            vneg_q;
	logic [RW-1:0]                   prem_q;
	logic [RW-1:0]                   vrem_q;

	// Output registers.
	wsvf_pkg::wheel_t                out_wheel_q;
	wsvf_pkg::pos_t                  out_pos_q;
	wsvf_pkg::vel_t                  out_vel_q;
	wsvf_pkg::pos_t                  out_avgh_q;
	wsvf_pkg::vel_t                  out_avgv_q;
	logic                            out_err_q;

	logic              take_sample;
	logic              load_result;
	logic              cnt_zero;
	logic [IDX_W-1:0]  widx;
	logic              wheel_ok;
	wsvf_pkg::mv_t     diff_mv;
	wsvf_pkg::pos_t    prev_pos;
	wsvf_pkg::vel_t    prev_vel;
	wsvf_pkg::pos_t    pos_new;
	logic signed [wsvf_pkg::DELTA_W-1:0] delta;
	logic [MV_W:0]     div_r2;
	logic              div_ge;
	logic signed [QW-1:0] acc_hi;
	logic              acc_fits;
	wsvf_pkg::vel_t    vel_sat;
	logic [RW-1:0]     p_r2;
	logic [RW-1:0]     v_r2;
	logic              p_ge;
	logic              v_ge;
	logic [VEL_W-1:0]  vquo;
	wsvf_pkg::vel_t    avgv;

	assign take_sample = samples.valid && samples.ready;
	assign load_result = (state_q == ST_DONE) && (!res_valid_q || results.ready);
	assign cnt_zero    = (cnt_q == '0);

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;

	// Wheel selection and the stored state of that wheel.
	assign widx     = IDX_W'(wheel_q);
	assign wheel_ok = (32'(wheel_q) < WHEELS);
	assign prev_pos = wheel_ok ? wpos_q[widx] : '0;
	assign prev_vel = wheel_ok ? wvel_q[widx] : '0;
	assign diff_mv  = samples.sample_mv - min_q;

	// One restoring step of the span divider.
	assign div_r2 = {rem_q, prod_q[PROD_W-1]};
	assign div_ge = (div_r2 >= {1'b0, span_q});

	// Quotient clamped to the 10-bit position range, forced to zero for an empty range
	// or a sample at or below the minimum.
	always_comb begin
		if (zero_q) begin
			pos_new = '0;
		end else if (|prod_q[PROD_W-1:POS_W]) begin
			pos_new = wsvf_pkg::POS_MAX;
		end else begin
			pos_new = prod_q[POS_W-1:0];
		end
	end
	assign delta = $signed({1'b0, pos_new}) - $signed({1'b0, prev_pos});

	// Drop the fraction bits and saturate the filter output to 16 bits.
	assign acc_hi   = acc_q[ACC_W-1:wsvf_pkg::FRAC_W];
	assign acc_fits = (&acc_hi[QW-1:VEL_W-1]) || !(|acc_hi[QW-1:VEL_W-1]);
	always_comb begin
		if (acc_fits) begin
			vel_sat = acc_hi[VEL_W-1:0];
		end else if (acc_hi[QW-1]) begin
			vel_sat = wsvf_pkg::VEL_MIN;
		end else begin
			vel_sat = wsvf_pkg::VEL_MAX;
		end
	end

	// One restoring step of each average divider, divisor WHEELS.
	assign p_r2 = {prem_q[RW-2:0], pdiv_q[VSUM_W-1]};
	assign v_r2 = {vrem_q[RW-2:0], vdiv_q[VSUM_W-1]};
	assign p_ge = (p_r2 >= RW'(WHEELS));
	assign v_ge = (v_r2 >= RW'(WHEELS));

	// Restore the sign of the velocity average.
	assign vquo = vdiv_q[VEL_W-1:0];
	assign avgv = vneg_q ? (~vquo + 1'b1) : vquo;

	// Sequencer, configuration registers, wheel state and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			min_q       <= wsvf_pkg::MIN_MV_RESET;
			max_q       <= wsvf_pkg::MAX_MV_RESET;
			fs_q        <= wsvf_pkg::FULL_STROKE_RESET;
			retain_q    <= wsvf_pkg::RETAIN_RESET;
			gain_q      <= wsvf_pkg::GAIN_RESET;
			psum_q      <= '0;
			vsum_q      <= '0;
			for (int i = 0; i < WHEELS; i++) begin
				wpos_q[i] <= '0;
				wvel_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					wsvf_pkg::REG_MIN_MV:      min_q    <= cfg.data[MV_W-1:0];
					wsvf_pkg::REG_MAX_MV:      max_q    <= cfg.data[MV_W-1:0];
					wsvf_pkg::REG_FULL_STROKE: fs_q     <= cfg.data[wsvf_pkg::STROKE_W-1:0];
					wsvf_pkg::REG_RETAIN_COEF: retain_q <= cfg.data[wsvf_pkg::RETAIN_W-1:0];
					wsvf_pkg::REG_DIFF_GAIN:   gain_q   <= cfg.data[wsvf_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end

			// A new result wins over the transfer of the old one.
			if (load_result) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end

			if (!cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (take_sample) begin
						state_q <= ST_MUL;
						cnt_q   <= CNT_W'(wsvf_pkg::MUL_STEPS - 1);
					end
				end
				ST_MUL: begin
					if (cnt_zero) begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(wsvf_pkg::DIV_STEPS - 1);
					end
				end
				ST_DIV: begin
					if (cnt_zero) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_VEL;
					cnt_q   <= CNT_W'(wsvf_pkg::VEL_STEPS - 1);
				end
				ST_VEL: begin
					if (cnt_zero) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_AVGL;
					if (wheel_ok) begin
						psum_q <= psum_q - PSUM_W'(prev_pos) + PSUM_W'(pos_q);
						vsum_q <= vsum_q - VSUM_W'(prev_vel) + VSUM_W'(vel_sat);
						wpos_q[widx] <= pos_q;
						wvel_q[widx] <= vel_sat;
					end
				end
				ST_AVGL: begin
					state_q <= ST_AVG;
					cnt_q   <= CNT_W'(AVG_STEPS - 1);
				end
				ST_AVG: begin
					if (cnt_zero) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_result) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Bit-serial datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_sample) begin
					wheel_q  <= samples.wheel;
					err_q    <= (max_q <= min_q);
					zero_q   <= (max_q <= min_q) || (samples.sample_mv <= min_q);
					span_q   <= max_q - min_q;
					prod_q   <= '0;
					mcand_q  <= PROD_W'(diff_mv);
					mplier_q <= fs_q;
				end
			end
			// Shift-add multiply of the millivolt offset by the full stroke.
			ST_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				rem_q    <= '0;
			end
			// Restoring divide by the span; the quotient shifts into prod_q.
			ST_DIV: begin
				rem_q  <= div_ge ? MV_W'(div_r2 - {1'b0, span_q}) : div_r2[MV_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], div_ge};
			end
			// Load the two filter products.
			ST_PREP: begin
				pos_q <= pos_new;
				acc_q <= '0;
				ma_q  <= ACC_W'(prev_vel);
				mb_q  <= ACC_W'(delta);
				ra_q  <= retain_q;
				rb_q  <= gain_q;
			end
			// Both products accumulate one multiplier bit per cycle.
			ST_VEL: begin
				acc_q <= acc_q + (ra_q[0] ? ma_q : '0) + (rb_q[0] ? mb_q : '0);
				ma_q  <= ma_q <<< 1;
				mb_q  <= mb_q <<< 1;
				ra_q  <= ra_q >> 1;
				rb_q  <= rb_q >> 1;
			end
			ST_SUM: begin
				res_pos_q <= wheel_ok ? pos_q : '0;
				res_vel_q <= wheel_ok ? vel_sat : '0;
			end
			ST_AVGL: begin
				pdiv_q <= VSUM_W'(psum_q);
				vneg_q <= vsum_q[VSUM_W-1];
				vdiv_q <= vsum_q[VSUM_W-1] ? VSUM_W'(-vsum_q) : VSUM_W'(vsum_q);
				prem_q <= '0;
				vrem_q <= '0;
			end
			// Restoring divide of both sums by the wheel count.
			ST_AVG: begin
				prem_q <= p_ge ? (p_r2 - RW'(WHEELS)) : p_r2;
				vrem_q <= v_ge ? (v_r2 - RW'(WHEELS)) : v_r2;
				pdiv_q <= {pdiv_q[VSUM_W-2:0], p_ge};
				vdiv_q <= {vdiv_q[VSUM_W-2:0], v_ge};
			end
			ST_DONE: begin
				if (load_result) begin
					out_wheel_q <= wheel_q;
					out_pos_q   <= res_pos_q;
					out_vel_q   <= res_vel_q;
					out_avgh_q  <= pdiv_q[POS_W-1:0];
					out_avgv_q  <= avgv;
					out_err_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid        = res_valid_q;
	assign results.wheel_out    = out_wheel_q;
	assign results.position_mm  = out_pos_q;
	assign results.velocity     = out_vel_q;
	assign results.avg_height   = out_avgh_q;
	assign results.avg_velocity = out_avgv_q;
	assign results.range_error  = out_err_q;

`ifndef SYNTHESIS
	// A sample transfer always starts the scaling multiply.
	a_start_mul: assert property (@(posedge clk) disable iff (!arst_n)
		take_sample |=> (state_q == ST_MUL))
		else $error("sample transfer did not start the multiply");

	// A wheel out of range leaves the running sums untouched.
	a_sums_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SUM) && !wheel_ok) |=> ($stable(psum_q) && $stable(vsum_q)))
		else $error("running sums changed for a wheel out of range");

	// A wheel out of range reports zero position and velocity.
	a_bad_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (32'(results.wheel_out) >= WHEELS)) |->
		((results.position_mm == '0) && (results.velocity == '0)))
		else $error("nonzero result for a wheel out of range");

	// An empty sensor range always reports position zero.
	a_range_err: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.range_error) |-> (results.position_mm == '0))
		else $error("nonzero position with a range error");
`endif

endmodule

[verif/wsvf_stroke_check.sv]
`timescale 1ns / 100ps
// Result checker for the wheel stroke and velocity filter. It watches the configuration,
// sample and result channels, predicts every result and compares it field by field.
// Depends on wsvf_pkg and the channel interfaces wsvf_cfg_if, wsvf_sample_if, wsvf_result_if.
module wsvf_stroke_check #(
	parameter int WHEELS = wsvf_pkg::WHEELS_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	wsvf_cfg_if    cfg,
	wsvf_sample_if samples,
	wsvf_result_if results,
	output int     fails,
	output int     pending
);
	import wsvf_pkg::*;

	localparam int SHOWN_MISMATCHES = 40;

	typedef struct packed {
		wheel_t wheel;
		pos_t   position;
		vel_t   velocity;
		pos_t   avg_height;
		vel_t   avg_velocity;
		logic   range_error;
	} stroke_result_t;

	// Our own copy of the registers.
	mv_t                 cfg_min;
	mv_t                 cfg_max;
	logic [STROKE_W-1:0] cfg_stroke;
	logic [RETAIN_W-1:0] cfg_retain;
	logic [GAIN_W-1:0]   cfg_gain;

	// Our own copy of the per-wheel state and the running sums.
	pos_t                pos_store [WHEELS];
	vel_t                vel_store [WHEELS];
	logic [12:0]         pos_total;
	logic signed [18:0]  vel_total;

	stroke_result_t      expected_strokes [$];
	stroke_result_t      observed;
	stroke_result_t      oldest;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fails < SHOWN_MISMATCHES) begin
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		end
		fails++;
	endtask

	// Linear scaling of the sensor voltage to stroke, truncated and saturated.
	function automatic pos_t scale_stroke(input mv_t mv, output logic err);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] quot;
		err = 1'b0;
		if (cfg_max <= cfg_min) begin
			err = 1'b1;
			return '0;
		end
		if (mv <= cfg_min) return '0;
		prod = (PROD_W'(mv) - PROD_W'(cfg_min)) * PROD_W'(cfg_stroke);
		quot = prod / PROD_W'(cfg_max - cfg_min);
		if (quot > PROD_W'(POS_MAX)) return POS_MAX;
		return pos_t'(quot);
	endfunction

	// First-order filtered difference; the shift floors, then saturate to 16 bits.
	function automatic vel_t filter_velocity(input vel_t prev,
		input logic signed [DELTA_W-1:0] delta);
		logic signed [47:0] acc;
		acc = $signed({1'b0, cfg_retain}) * prev + $signed({1'b0, cfg_gain}) * delta;
		acc = acc >>> FRAC_W;
		if (acc > VEL_MAX) return VEL_MAX;
		if (acc < VEL_MIN) return VEL_MIN;
		return vel_t'(acc);
	endfunction

	// Work out one result and advance the wheel state; wheels out of range change nothing.
	function automatic stroke_result_t predict_stroke(input wheel_t w, input mv_t mv);
		stroke_result_t              r;
		logic                        err;
		pos_t                        pos;
		vel_t                        vel;
		logic signed [DELTA_W-1:0]   delta;
		pos = scale_stroke(mv, err);
		vel = '0;
		if (w < WHEELS) begin
			delta = $signed({1'b0, pos}) - $signed({1'b0, pos_store[w]});
			vel = filter_velocity(vel_store[w], delta);
			pos_total = pos_total - pos_store[w] + pos;
			vel_total = vel_total - vel_store[w] + vel;
			pos_store[w] = pos;
			vel_store[w] = vel;
		end else begin
			pos = '0;
		end
		r.wheel        = w;
		r.position     = pos;
		r.velocity     = vel;
		r.avg_height   = pos_t'(pos_total / WHEELS);
		r.avg_velocity = vel_t'(vel_total / WHEELS);
		r.range_error  = err;
		return r;
	endfunction

	// Track register writes, queue a prediction per sample, compare each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min    = MIN_MV_RESET;
			cfg_max    = MAX_MV_RESET;
			cfg_stroke = FULL_STROKE_RESET;
			cfg_retain = RETAIN_RESET;
			cfg_gain   = GAIN_RESET;
			for (int i = 0; i < WHEELS; i++) begin
				pos_store[i] = '0;
				vel_store[i] = '0;
			end
			pos_total = '0;
			vel_total = '0;
			expected_strokes.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_MV:      cfg_min    = cfg.data[MV_W-1:0];
					REG_MAX_MV:      cfg_max    = cfg.data[MV_W-1:0];
					REG_FULL_STROKE: cfg_stroke = cfg.data[STROKE_W-1:0];
					REG_RETAIN_COEF: cfg_retain = cfg.data[RETAIN_W-1:0];
					REG_DIFF_GAIN:   cfg_gain   = cfg.data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				expected_strokes.push_back(predict_stroke(samples.wheel, samples.sample_mv));
			end
			if (results.valid && results.ready) begin
				observed.wheel        = results.wheel_out;
				observed.position     = results.position_mm;
				observed.velocity     = results.velocity;
				observed.avg_height   = results.avg_height;
				observed.avg_velocity = results.avg_velocity;
				observed.range_error  = results.range_error;
				if (expected_strokes.size() == 0) begin
					report_mismatch("result with nothing pending, wheel_out", observed.wheel, -1);
				end else begin
					oldest = expected_strokes.pop_front();
					if (observed.wheel != oldest.wheel)
						report_mismatch("wheel_out", observed.wheel, oldest.wheel);
					if (observed.position != oldest.position)
						report_mismatch("position_mm", observed.position, oldest.position);
					if (observed.velocity != oldest.velocity)
						report_mismatch("velocity", int'(observed.velocity),
							int'(oldest.velocity));
					if (observed.avg_height != oldest.avg_height)
						report_mismatch("avg_height", observed.avg_height, oldest.avg_height);
					if (observed.avg_velocity != oldest.avg_velocity)
						report_mismatch("avg_velocity", int'(observed.avg_velocity),
							int'(oldest.avg_velocity));
					if (observed.range_error != oldest.range_error)
						report_mismatch("range_error", observed.range_error,
							oldest.range_error);
				end
			end
			pending = expected_strokes.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the wheel stroke and velocity filter: clock, reset, register settings,
// sensor samples, result back-pressure and the verdict. Depends on wsvf_pkg, the channel
// interfaces, wheel_stroke_velocity_filter_unit and the checker wsvf_stroke_check.
module tb;
	import wsvf_pkg::*;

	localparam int WHEELS           = WHEELS_DEFAULT;
	localparam int CYCLE_LIMIT      = 2_000_000;
	localparam int PHASES           = 12;
	localparam int PHASE_ITEMS      = 130;
	localparam int SETTLE_CYCLES    = 80;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int LONG_HOLD_AFTER  = 400;
	localparam int WHEEL_TOP        = (1 << WHEEL_W) - 1;
	localparam int MV_TOP           = (1 << MV_W) - 1;
	localparam int CFG_IDX_TOP      = (1 << CFG_IDX_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_DIFF_GAIN + 3'd1;

	logic clk;
	logic arst_n;
	logic steady;
	int   samples_sent;
	int   fails;
	int   pending;
	int   cycle_count;
	mv_t  cur_min;
	mv_t  cur_max;
	mv_t  last_mv [WHEEL_TOP+1];

	wsvf_cfg_if    cfg_ch ();
	wsvf_sample_if sample_ch ();
	wsvf_result_if result_ch ();

	wheel_stroke_velocity_filter_unit #(.WHEELS(WHEELS)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (sample_ch),
		.results (result_ch)
	);

	wsvf_stroke_check #(.WHEELS(WHEELS)) stroke_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (sample_ch),
		.results (result_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly no gap, some short ones, a few long enough to span a whole computation.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Most samples go to real wheels; the rest address the two unused slots.
	function automatic wheel_t pick_wheel();
		if ($urandom_range(0, 9) != 0) return wheel_t'($urandom_range(0, WHEELS - 1));
		return wheel_t'($urandom_range(WHEELS, WHEEL_TOP));
	endfunction

	// Smooth arm motion around the last reading, in-range values, the range ends, or noise.
	function automatic mv_t pick_mv(input wheel_t w);
		int r;
		int mv;
		r = $urandom_range(0, 99);
		if (r < 35 && w < WHEELS) begin
			mv = int'(last_mv[w]) + int'($urandom_range(0, 400)) - 200;
			if (mv < 0) mv = 0;
			if (mv > MV_TOP) mv = MV_TOP;
			return mv_t'(mv);
		end
		if (r < 70 && cur_min < cur_max) return mv_t'($urandom_range(cur_min, cur_max));
		if (r < 80) return ($urandom_range(0, 1) != 0) ? cur_min : cur_max;
		if (r < 85) return ($urandom_range(0, 1) != 0) ? mv_t'(0) : mv_t'(MV_TOP);
		return mv_t'($urandom_range(0, MV_TOP));
	endfunction

	// One sample transfer, then an optional gap; valid stays high when there is none.
	task automatic send_sample(input wheel_t w, input mv_t mv);
		sample_ch.valid     <= 1'b1;
		sample_ch.wheel     <= w;
		sample_ch.sample_mv <= mv;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		@(negedge clk);
		samples_sent++;
		last_mv[w] = mv;
		idle_sender(pick_gap());
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Stop offering samples and wait until every predicted result has been taken.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Program all registers while idle, plus one write to an unused index.
	task automatic apply_setting(input mv_t lo_mv, input mv_t hi_mv,
		input logic [STROKE_W-1:0] stroke, input logic [RETAIN_W-1:0] retain,
		input logic [GAIN_W-1:0] gain);
		drain_results();
		write_reg(REG_MIN_MV, CFG_DATA_W'(lo_mv));
		write_reg(REG_MAX_MV, CFG_DATA_W'(hi_mv));
		write_reg(REG_FULL_STROKE, CFG_DATA_W'(stroke));
		write_reg(REG_RETAIN_COEF, CFG_DATA_W'(retain));
		write_reg(REG_DIFF_GAIN, CFG_DATA_W'(gain));
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE_FIRST), CFG_IDX_TOP)),
			CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
		cur_min = lo_mv;
		cur_max = hi_mv;
	endtask

	// Result side: random holds, one long hold once the traffic is going.
	initial begin
		int   hold;
		logic long_hold_done;
		hold = 0;
		long_hold_done = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && samples_sent >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD_CYCLES;
			end else if (hold == 0 && !steady && $urandom_range(0, 99) < 15) begin
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
					: $urandom_range(1, 5);
			end
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus: directed cases first, then random phases under varied register settings.
	initial begin
		mv_t                 lo_mv;
		mv_t                 hi_mv;
		logic [STROKE_W-1:0] stroke;
		logic [RETAIN_W-1:0] retain;
		logic [GAIN_W-1:0]   gain;
		arst_n              = 1'b0;
		steady              = 1'b0;
		samples_sent        = 0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.wheel     = '0;
		sample_ch.sample_mv = '0;
		cur_min             = MIN_MV_RESET;
		cur_max             = MAX_MV_RESET;
		foreach (last_mv[i]) last_mv[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: below minimum, above maximum, exact range ends, unused wheels.
		send_sample(0, mv_t'(0));
		send_sample(1, mv_t'(MV_TOP));
		send_sample(2, MAX_MV_RESET);
		send_sample(3, MIN_MV_RESET);
		send_sample(3, mv_t'(MIN_MV_RESET + 1));
		send_sample(wheel_t'(WHEELS), mv_t'(3000));
		send_sample(wheel_t'(WHEEL_TOP), mv_t'(MV_TOP));
		send_sample(1, mv_t'(0));

		// Empty sensor range flags an error and forces position zero.
		apply_setting(mv_t'(4000), mv_t'(4000), FULL_STROKE_RESET, RETAIN_RESET, GAIN_RESET);
		send_sample(4, mv_t'(MV_TOP));
		send_sample(wheel_t'(WHEEL_TOP), mv_t'(100));

		// Ratchet wheel 0: rise with full gain, fall back with none, until velocity saturates.
		for (int k = 0; k < 3; k++) begin
			apply_setting('0, mv_t'(1), '1, '1, '0);
			send_sample(0, mv_t'(0));
			apply_setting('0, mv_t'(1), '1, '1, '1);
			send_sample(0, mv_t'(MV_TOP));
		end
		// And the other way down to negative saturation.
		for (int k = 0; k < 5; k++) begin
			apply_setting('0, mv_t'(1), '1, '1, '1);
			send_sample(0, mv_t'(0));
			apply_setting('0, mv_t'(1), '1, '1, '0);
			send_sample(0, mv_t'(MV_TOP));
		end

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < PHASES; phase++) begin
			lo_mv  = mv_t'($urandom_range(0, 4000));
			hi_mv  = mv_t'($urandom_range(int'(lo_mv) + 1, MV_TOP));
			stroke = STROKE_W'($urandom_range(0, (1 << STROKE_W) - 1));
			retain = RETAIN_W'($urandom);
			gain   = GAIN_W'($urandom);
			case (phase)
				1: begin
					lo_mv  = '0;
					hi_mv  = '1;
					stroke = '1;
					retain = '1;
					gain   = '1;
				end
				2: begin
					lo_mv = '1;
					hi_mv = '0;
				end
				3: begin
					retain = '0;
					gain   = '0;
				end
				4: begin
					lo_mv  = MIN_MV_RESET;
					hi_mv  = MAX_MV_RESET;
					stroke = FULL_STROKE_RESET;
					retain = RETAIN_RESET;
					gain   = GAIN_RESET;
				end
				5: hi_mv = lo_mv;
				6: begin
					hi_mv  = lo_mv + mv_t'($urandom_range(1, 20));
					stroke = '1;
				end
				7: stroke = '0;
				default: ;
			endcase
			apply_setting(lo_mv, hi_mv, stroke, retain, gain);
			steady = (phase % 4 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				wheel_t w;
				w = pick_wheel();
				send_sample(w, pick_mv(w));
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
